/* design/assert_macros.svh */
// Assertion macros used by the layer color range query RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

/* design/lcrq_pkg.sv */
// Types and constants for the layer color range query core.
package lcrq_pkg;

  localparam int MAX_LAYERS_DEF = 1024;
  localparam int LAYER_W        = 11;
  localparam int CHAN_W         = 8;
  localparam int CHAN_MAX       = 255;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_IDX,
    ST_PFX
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               replaces;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;
    logic [LAYER_W-1:0] first_layer;
    logic [LAYER_W-1:0] last_layer;
  } cmd_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              bad_range;
  } result_t;

endpackage

/* design/layer_color_range_query_core.sv */
// Layer color range query core: segmented prefix sums over stored RGB layers.
// Append/clear apply at the accept edge; busy stays low; one per cycle unless busy.
// A query raises busy for one cycle; done pulses as ST_PFX registers the result.
// A query reads index and last prefix, then base prefix; ST_PFX takes the next.
// Reset clears the layer count and control state; the RAMs are not cleared.
// Results cannot be stalled by the receiver.
`include "assert_macros.svh"
module layer_color_range_query_core #(
  parameter int MAX_LAYERS = lcrq_pkg::MAX_LAYERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lcrq_pkg::cmd_t   cmd,
  output logic             done,
  output lcrq_pkg::result_t result
);

  localparam int AW = $clog2(MAX_LAYERS);
  localparam int CW = $clog2(MAX_LAYERS + 1);
  localparam int QW = (CW > lcrq_pkg::LAYER_W) ? CW : lcrq_pkg::LAYER_W;
  localparam int PW = $clog2(lcrq_pkg::CHAN_MAX * MAX_LAYERS + 1);
  localparam int CH = lcrq_pkg::CHAN_W;

  lcrq_pkg::state_t state, state_next;

  logic [CW-1:0]   layer_count;
  logic [PW-1:0]   tail_r, tail_g, tail_b;
  logic [CW-1:0]   tail_idx;

  logic [lcrq_pkg::LAYER_W-1:0] q_first;
  logic            q_bad;
  logic            below_zero;
  logic [3*PW-1:0] pfx_last;

  logic            accept, do_append, do_query, do_clear;
  logic            idx_re, pfx_re;
  logic [AW-1:0]   pfx_raddr, last_addr;
  logic [CW-1:0]   idx_rdata;
  logic [3*PW-1:0] pfx_rdata, pfx_wdata;
  logic [CW-1:0]   new_idx;
  logic [QW-1:0]   last_ext, first_ext, count_ext, start_ext, below_ext, lri_ext;
  logic            bad_now;
  logic [PW-1:0]   pb_r, pb_g, pb_b, d_r, d_g, d_b;
  lcrq_pkg::result_t result_next;

  assign busy      = (state == lcrq_pkg::ST_IDX);
  assign accept    = start && !busy;
  assign do_append = accept && (cmd.action == lcrq_pkg::ACT_APPEND) &&
                     (layer_count != CW'(MAX_LAYERS));
  assign do_query  = accept && (cmd.action == lcrq_pkg::ACT_QUERY);
  assign do_clear  = accept && (cmd.action == lcrq_pkg::ACT_CLEAR);

  assign last_ext  = QW'(cmd.last_layer);
  assign first_ext = QW'(cmd.first_layer);
  assign count_ext = QW'(layer_count);
  assign bad_now   = (cmd.first_layer == '0) || (first_ext > last_ext) ||
                     (last_ext > count_ext);
  assign last_addr = AW'(last_ext - QW'(1));

  assign new_idx   = cmd.replaces ? (layer_count + CW'(1)) : tail_idx;
  assign pfx_wdata = {tail_r + PW'(cmd.red_in), tail_g + PW'(cmd.green_in),
                      tail_b + PW'(cmd.blue_in)};

  assign lri_ext   = QW'(idx_rdata);
  assign start_ext = (lri_ext < QW'(q_first)) ? QW'(q_first) : lri_ext;
  assign below_ext = start_ext - QW'(1);

  assign idx_re    = do_query;
  assign pfx_re    = do_query || (state == lcrq_pkg::ST_IDX);
  assign pfx_raddr = (state == lcrq_pkg::ST_IDX) ? AW'(below_ext - QW'(1)) : last_addr;

  lcrq_ram #(.WIDTH(CW), .DEPTH(MAX_LAYERS)) u_idx_ram (
    .clk   (clk),
    .we    (do_append),
    .waddr (AW'(layer_count)),
    .wdata (new_idx),
    .re    (idx_re),
    .raddr (last_addr),
    .rdata (idx_rdata)
  );

  lcrq_ram #(.WIDTH(3*PW), .DEPTH(MAX_LAYERS)) u_pfx_ram (
    .clk   (clk),
    .we    (do_append),
    .waddr (AW'(layer_count)),
    .wdata (pfx_wdata),
    .re    (pfx_re),
    .raddr (pfx_raddr),
    .rdata (pfx_rdata)
  );

  always_comb begin
    pb_r = below_zero ? '0 : pfx_rdata[3*PW-1:2*PW];
    pb_g = below_zero ? '0 : pfx_rdata[2*PW-1:PW];
    pb_b = below_zero ? '0 : pfx_rdata[PW-1:0];
    d_r  = pfx_last[3*PW-1:2*PW] - pb_r;
    d_g  = pfx_last[2*PW-1:PW] - pb_g;
    d_b  = pfx_last[PW-1:0] - pb_b;
    result_next.red_out   = (d_r > PW'(lcrq_pkg::CHAN_MAX)) ? CH'(lcrq_pkg::CHAN_MAX) : CH'(d_r);
    result_next.green_out = (d_g > PW'(lcrq_pkg::CHAN_MAX)) ? CH'(lcrq_pkg::CHAN_MAX) : CH'(d_g);
    result_next.blue_out  = (d_b > PW'(lcrq_pkg::CHAN_MAX)) ? CH'(lcrq_pkg::CHAN_MAX) : CH'(d_b);
    result_next.bad_range = q_bad;
    if (q_bad) begin
      result_next.red_out   = '0;
      result_next.green_out = '0;
      result_next.blue_out  = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lcrq_pkg::ST_IDLE: begin
        if (do_query) state_next = lcrq_pkg::ST_IDX;
      end
      lcrq_pkg::ST_IDX: begin
        state_next = lcrq_pkg::ST_PFX;
      end
      lcrq_pkg::ST_PFX: begin
        state_next = do_query ? lcrq_pkg::ST_IDX : lcrq_pkg::ST_IDLE;
      end
      default: begin
        state_next = lcrq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lcrq_pkg::ST_IDLE;
      done        <= 1'b0;
      layer_count <= '0;
      tail_r      <= '0;
      tail_g      <= '0;
      tail_b      <= '0;
      tail_idx    <= '0;
    end else begin
      state <= state_next;
      done  <= (state == lcrq_pkg::ST_PFX);
      if (do_append) begin
        layer_count <= layer_count + CW'(1);
        tail_r      <= pfx_wdata[3*PW-1:2*PW];
        tail_g      <= pfx_wdata[2*PW-1:PW];
        tail_b      <= pfx_wdata[PW-1:0];
        tail_idx    <= new_idx;
      end else if (do_clear) begin
        layer_count <= '0;
        tail_r      <= '0;
        tail_g      <= '0;
        tail_b      <= '0;
        tail_idx    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      q_first <= cmd.first_layer;
      q_bad   <= bad_now;
    end
    if (state == lcrq_pkg::ST_IDX) begin
      pfx_last   <= pfx_rdata;
      below_zero <= (below_ext == '0);
    end
    if (state == lcrq_pkg::ST_PFX) begin
      result <= result_next;
    end
  end

  `ASSERT_CLK(a_done_after_pfx, clk, rst, done |-> $past(state == lcrq_pkg::ST_PFX), "done without query")
  `ASSERT_CLK(a_query_busy, clk, rst, do_query |=> busy, "query did not raise busy")
  `ASSERT_CLK(a_busy_one_cycle, clk, rst, busy |=> !busy, "busy held past one cycle")
  `ASSERT_NEVER(a_count_range, clk, rst, layer_count > CW'(MAX_LAYERS), "layer count overflow")

endmodule

/* design/lcrq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module lcrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* test/tb_layer_color_range_query_core.sv */
// Testbench for layer_color_range_query_core: directed table, random traffic, scoreboard.
module tb_layer_color_range_query_core;
  import lcrq_pkg::*;

  localparam int LAYERS = MAX_LAYERS_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX = 10;
  localparam int RAND_PER_PHASE = 266;

  typedef struct packed {
    cmd_t    c;
    logic    typed;
    result_t want;
  } row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  layer_color_range_query_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // predictor state
  int unsigned        layer_cnt = 0;
  logic [17:0]        red_sum [0:LAYERS];
  logic [17:0]        grn_sum [0:LAYERS];
  logic [17:0]        blu_sum [0:LAYERS];
  logic [LAYER_W-1:0] repl_at [0:LAYERS];
  result_t            pending_rgb [$];

  logic    typed_vld = 1'b0;
  result_t typed_rgb = '0;
  int      idle_pct = 0;
  int      errors = 0;
  int      idle_cycles = 0;
  int      results_seen = 0;
  int      appends = 0, full_drops = 0, queries = 0, bad_queries = 0;
  int      clears = 0, unused_ops = 0;
  row_t    plan [24];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [CHAN_W-1:0] clamp_chan(logic [17:0] v);
    return (v > CHAN_MAX) ? CHAN_W'(CHAN_MAX) : v[CHAN_W-1:0];
  endfunction

  function automatic void predict_blend(input cmd_t c, output bit has_res,
                                        output result_t r);
    int unsigned n;
    int unsigned lo;
    has_res = 1'b0;
    r = '0;
    case (c.action)
      ACT_APPEND: begin
        if (layer_cnt >= LAYERS) begin
          full_drops++;
        end else begin
          n = layer_cnt + 1;
          red_sum[n] = red_sum[n-1] + c.red_in;
          grn_sum[n] = grn_sum[n-1] + c.green_in;
          blu_sum[n] = blu_sum[n-1] + c.blue_in;
          repl_at[n] = c.replaces ? LAYER_W'(n) : repl_at[n-1];
          layer_cnt = n;
          appends++;
        end
      end
      ACT_CLEAR: begin
        layer_cnt = 0;
        clears++;
      end
      ACT_QUERY: begin
        has_res = 1'b1;
        queries++;
        if (c.first_layer == 0 || c.first_layer > c.last_layer ||
            c.last_layer > layer_cnt) begin
          r.bad_range = 1'b1;
          bad_queries++;
        end else begin
          lo = repl_at[c.last_layer];
          if (lo < c.first_layer) lo = c.first_layer;
          r.red_out   = clamp_chan(red_sum[c.last_layer] - red_sum[lo-1]);
          r.green_out = clamp_chan(grn_sum[c.last_layer] - grn_sum[lo-1]);
          r.blue_out  = clamp_chan(blu_sum[c.last_layer] - blu_sum[lo-1]);
        end
      end
      default: begin
        unused_ops++;
      end
    endcase
  endfunction

  function automatic void report_fault(string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("[%0t] ERROR: %s", $time, msg);
  endfunction

  function automatic string fmt_rgb(result_t r);
    return $sformatf("r=%h g=%h b=%h bad=%b", r.red_out, r.green_out, r.blue_out,
                     r.bad_range);
  endfunction

  // scoreboard and transaction monitor
  always @(posedge clk) begin
    bit      has_res;
    result_t want;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (pending_rgb.size() == 0) begin
          report_fault($sformatf("unexpected result %s", fmt_rgb(result)));
        end else begin
          want = pending_rgb.pop_front();
          if (result.red_out !== want.red_out || result.green_out !== want.green_out ||
              result.blue_out !== want.blue_out || result.bad_range !== want.bad_range)
            report_fault($sformatf("exp %s, got %s", fmt_rgb(want), fmt_rgb(result)));
        end
      end
      if (start && !busy) begin
        predict_blend(cmd, has_res, want);
        if (has_res) pending_rgb = {pending_rgb, (typed_vld ? typed_rgb : want)};
      end
      idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  function automatic cmd_t op(logic [1:0] a, logic rp, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b, logic [LAYER_W-1:0] f,
                              logic [LAYER_W-1:0] l);
    cmd_t c;
    c.action = a;
    c.replaces = rp;
    c.red_in = r;
    c.green_in = g;
    c.blue_in = b;
    c.first_layer = f;
    c.last_layer = l;
    return c;
  endfunction

  function automatic result_t rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                  logic bad);
    result_t x;
    x.red_out = r;
    x.green_out = g;
    x.blue_out = b;
    x.bad_range = bad;
    return x;
  endfunction

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned pick;
    c.replaces = ($urandom_range(0, 3) == 0);
    c.red_in = pick_chan();
    c.green_in = pick_chan();
    c.blue_in = pick_chan();
    c.first_layer = LAYER_W'($urandom_range(0, 2047));
    c.last_layer = LAYER_W'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (pick < 40 || (layer_cnt == 0 && pick < 85)) begin
      c.action = ACT_APPEND;
    end else if (pick < 85) begin
      c.action = ACT_QUERY;
      c.last_layer = LAYER_W'($urandom_range(1, layer_cnt));
      c.first_layer = LAYER_W'($urandom_range(1, c.last_layer));
    end else if (pick < 93) begin
      c.action = ACT_QUERY;
      case ($urandom_range(0, 3))
        0: c.first_layer = '0;
        1: begin
          c.last_layer = LAYER_W'(layer_cnt + 1);
          c.first_layer = LAYER_W'($urandom_range(1, c.last_layer));
        end
        2: begin
          c.first_layer = LAYER_W'($urandom_range(2, 2047));
          c.last_layer = LAYER_W'($urandom_range(1, c.first_layer - 1));
        end
        default: ;
      endcase
    end else if (pick < 97) begin
      c.action = ACT_CLEAR;
    end else begin
      c.action = ACT_UNUSED;
    end
    return c;
  endfunction

  // inputs move on the falling edge; start stays up across back-to-back transactions
  task automatic send(input cmd_t c, input logic tv = 1'b0, input result_t tr = '0);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    typed_vld <= tv;
    typed_rgb <= tr;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_rgb.size() != 0) @(negedge clk);
  endtask

  task automatic fill_to_top();
    cmd_t c;
    c = op(ACT_CLEAR, 1'b0, 8'h00, 8'h00, 8'h00, '0, '0);
    send(c);
    while (layer_cnt < LAYERS) begin
      c = rand_cmd();
      c.action = ACT_APPEND;
      c.replaces = ($urandom_range(0, 9) == 0);
      send(c);
    end
    repeat (3) begin
      c.red_in = pick_chan();
      send(c);
    end
    c.action = ACT_QUERY;
    c.first_layer = 1;
    c.last_layer = LAYER_W'(LAYERS);
    send(c);
    c.first_layer = LAYER_W'(LAYERS);
    send(c);
    c.first_layer = 1;
    c.last_layer = LAYER_W'(LAYERS + 1);
    send(c);
    repeat (30) begin
      c.last_layer = LAYER_W'($urandom_range(1, LAYERS));
      c.first_layer = LAYER_W'($urandom_range(1, c.last_layer));
      send(c);
    end
    c.action = ACT_CLEAR;
    send(c);
  endtask

  initial begin
    int pct [3];
    red_sum[0] = '0;
    grn_sum[0] = '0;
    blu_sum[0] = '0;
    repl_at[0] = '0;
    pct = '{30, 49, 0};
    plan = '{
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd1,    11'd1),    1'b1,
        rgb(8'h00, 8'h00, 8'h00, 1'b1)},
      '{op(ACT_QUERY,  1'b0, 8'hff, 8'hff, 8'hff, 11'd0,    11'd0),    1'b1,
        rgb(8'h00, 8'h00, 8'h00, 1'b1)},
      '{op(ACT_APPEND, 1'b1, 8'hff, 8'hff, 8'hff, 11'd0,    11'd0),    1'b0, '0},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd1,    11'd1),    1'b1,
        rgb(8'hff, 8'hff, 8'hff, 1'b0)},
      '{op(ACT_APPEND, 1'b0, 8'h00, 8'h00, 8'h00, 11'h7ff,  11'h7ff),  1'b0, '0},
      '{op(ACT_APPEND, 1'b0, 8'hff, 8'h00, 8'h01, 11'd0,    11'd0),    1'b0, '0},
      // red and blue sums exceed 255 and clamp; green sums to exactly 255
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd1,    11'd3),    1'b1,
        rgb(8'hff, 8'hff, 8'hff, 1'b0)},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd2,    11'd3),    1'b0, '0},
      '{op(ACT_APPEND, 1'b1, 8'h12, 8'h34, 8'h56, 11'd0,    11'd0),    1'b0, '0},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd1,    11'd4),    1'b0, '0},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd3,    11'd2),    1'b1,
        rgb(8'h00, 8'h00, 8'h00, 1'b1)},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd1,    11'd5),    1'b1,
        rgb(8'h00, 8'h00, 8'h00, 1'b1)},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'h7ff,  11'h7ff),  1'b1,
        rgb(8'h00, 8'h00, 8'h00, 1'b1)},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd0,    11'd4),    1'b1,
        rgb(8'h00, 8'h00, 8'h00, 1'b1)},
      '{op(ACT_UNUSED, 1'b1, 8'hff, 8'hff, 8'hff, 11'h7ff,  11'h7ff),  1'b0, '0},
      '{op(ACT_APPEND, 1'b0, 8'h00, 8'hff, 8'h00, 11'h400,  11'h400),  1'b0, '0},
      '{op(ACT_QUERY,  1'b1, 8'hab, 8'hcd, 8'hef, 11'd5,    11'd5),    1'b0, '0},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd4,    11'd5),    1'b0, '0},
      '{op(ACT_CLEAR,  1'b1, 8'hff, 8'hff, 8'hff, 11'h7ff,  11'h7ff),  1'b0, '0},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd1,    11'd1),    1'b1,
        rgb(8'h00, 8'h00, 8'h00, 1'b1)},
      '{op(ACT_APPEND, 1'b0, 8'h01, 8'h02, 8'h03, 11'd0,    11'd0),    1'b0, '0},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd1,    11'd1),    1'b1,
        rgb(8'h01, 8'h02, 8'h03, 1'b0)},
      '{op(ACT_CLEAR,  1'b0, 8'h00, 8'h00, 8'h00, 11'd0,    11'd0),    1'b0, '0},
      '{op(ACT_QUERY,  1'b0, 8'h00, 8'h00, 8'h00, 11'd1,    11'd1),    1'b1,
        rgb(8'h00, 8'h00, 8'h00, 1'b1)}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_pct = 30;
    foreach (plan[i]) send(plan[i].c, plan[i].typed, plan[i].want);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = pct[ph];
      repeat (RAND_PER_PHASE) send(rand_cmd());
      if (ph == 1) fill_to_top();
      drain();
    end

    repeat (8) @(negedge clk);
    while (pending_rgb.size() != 0) begin
      void'(pending_rgb.pop_front());
      report_fault("expected result never arrived");
    end

    $display("covered %0d appends (%0d dropped on a full list), %0d clears, %0d unused ops",
             appends, full_drops, clears, unused_ops);
    $display("checked %0d query results, %0d of them out of range; %0d errors",
             results_seen, bad_queries, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
